FILE: hdl/rthbp_pkg.sv
// rthbp_pkg: shared types and constants for the rgb to bitplane packer
// no dependencies; imported by rthbp_luma, rthbp_pack and the top level

package rthbp_pkg;

    // frame geometry
    localparam int unsigned FRAME_WIDTH  = 512;
    localparam int unsigned FRAME_HEIGHT = 384;
    localparam int unsigned COL_W        = 9;
    localparam int unsigned LINE_W       = 9;

    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(FRAME_WIDTH - 1);
    localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(FRAME_HEIGHT - 1);

    // luma weights, sum is scaled by 100
    localparam int unsigned   SUM_W     = 15;
    localparam logic [SUM_W-1:0] COEF_RED   = 15'd30;
    localparam logic [SUM_W-1:0] COEF_GREEN = 15'd59;
    localparam logic [SUM_W-1:0] COEF_BLUE  = 15'd11;
    localparam logic [SUM_W-1:0] LUMA_SCALE = 15'd100;

    // white when sum >= 100 * (threshold + 1); reset threshold is 127
    localparam logic [7:0]       THRESHOLD_RESET = 8'd127;
    localparam logic [SUM_W-1:0] LIMIT_RESET     = 15'd12800;

    // pixel position within the frame
    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [LINE_W-1:0] line;
    } pix_pos_t;

endpackage

FILE: hdl/rthbp_luma.sv
// rthbp_luma: weighted luma sum and threshold compare for one pixel
// depends on rthbp_pkg

module rthbp_luma
    import rthbp_pkg::*;
(
    input  logic [7:0]       red,
    input  logic [7:0]       green,
    input  logic [7:0]       blue,
    input  logic [SUM_W-1:0] limit,
    output logic             white
);

    logic [SUM_W-1:0] luma_sum;

    // floor(sum / 100) > t is the same as sum >= 100 * (t + 1)
    always_comb
    begin
        luma_sum = SUM_W'(red)   * COEF_RED
                 + SUM_W'(green) * COEF_GREEN
                 + SUM_W'(blue)  * COEF_BLUE;
        white    = (luma_sum >= limit);
    end

endmodule

FILE: hdl/rthbp_pack.sv
// rthbp_pack: bit shifter, screen address and result register
// depends on rthbp_pkg

module rthbp_pack
    import rthbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  logic        white,
    input  pix_pos_t    pos,
    output logic        can_take,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  screen_byte,
    output logic [1:0]  page,
    output logic [12:0] page_offset,
    output logic        frame_end
);

    logic [6:0]  pending_reg;
    logic [6:0]  pending_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  byte_reg;
    logic [1:0]  page_reg;
    logic [12:0] offset_reg;
    logic        end_reg;

    logic        boundary;
    logic        emit;
    logic [7:0]  row;
    logic [1:0]  page_calc;
    logic [12:0] offset_calc;
    logic        end_calc;

    // eighth pixel of a byte produces an item
    always_comb
    begin
        boundary = (pos.col[2:0] == 3'b111);
        can_take = !boundary || !out_valid_reg || out_ready;
        emit     = fire && boundary;
    end

    // interleaved layout: third, scanline in char row, char row, column pair
    always_comb
    begin
        row         = pos.line[8:1];
        page_calc   = {pos.line[0], pos.col[3]};
        offset_calc = {row[7:6], row[2:0], row[5:3], pos.col[8:4]};
        end_calc    = (pos.line == LAST_LINE) && (pos.col == LAST_COL);
    end

    // last seven white bits
    always_comb
    begin
        pending_next = fire ? {pending_reg[5:0], white} : pending_reg;
    end

    // result valid flag
    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            byte_reg   <= {pending_reg, white};
            page_reg   <= page_calc;
            offset_reg <= offset_calc;
            end_reg    <= end_calc;
        end
    end

    assign out_valid   = out_valid_reg;
    assign screen_byte = byte_reg;
    assign page        = page_reg;
    assign page_offset = offset_reg;
    assign frame_end   = end_reg;

endmodule

FILE: hdl/rgb_to_hires_bitplane_packer.sv
// rgb_to_hires_bitplane_packer: top level, thresholds rgb pixels and packs bitplane bytes
// an accepted pixel is held in the pixel register, then moves on to the result register
// throughput: one pixel per cycle unless the pixel register stalls; one result item per eight pixels
// the pixel register stalls only when a byte is due and the result is still held
// reset (async, active low): counters, valid flags and shift bits clear, threshold returns to 127
// depends on rthbp_pkg, rthbp_luma, rthbp_pack

module rgb_to_hires_bitplane_packer
    import rthbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  screen_byte,
    output logic [1:0]  page,
    output logic [12:0] page_offset,
    output logic        frame_end
);

    logic [SUM_W-1:0]  limit_reg;
    logic [SUM_W-1:0]  limit_next;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [LINE_W-1:0] line_reg;
    logic [LINE_W-1:0] line_next;
    logic              a_valid_reg;
    logic              a_valid_next;
    logic [7:0]        red_reg;
    logic [7:0]        green_reg;
    logic [7:0]        blue_reg;
    pix_pos_t          pos_reg;

    logic              in_accept;
    logic              a_fire;
    logic              can_take;
    logic              white;

    // handshake on the pixel register
    always_comb
    begin
        a_fire    = a_valid_reg && can_take;
        in_ready  = !a_valid_reg || a_fire;
        in_accept = in_valid && in_ready;
    end

    // threshold kept as the scaled compare limit
    always_comb
    begin
        limit_next = limit_reg;
        if (cfg_wr_en)
            limit_next = SUM_W'(cfg_wr_data) * LUMA_SCALE + LUMA_SCALE;
    end

    // raster position counters
    always_comb
    begin
        col_next  = col_reg;
        line_next = line_reg;
        if (in_accept)
        begin
            col_next = col_reg + 1'b1;
            if (col_reg == LAST_COL)
                line_next = (line_reg == LAST_LINE) ? '0 : line_reg + 1'b1;
        end
    end

    // pixel register occupancy
    always_comb
    begin
        if (in_accept)
            a_valid_next = 1'b1;
        else if (a_fire)
            a_valid_next = 1'b0;
        else
            a_valid_next = a_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= LIMIT_RESET;
            col_reg     <= '0;
            line_reg    <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            limit_reg   <= limit_next;
            col_reg     <= col_next;
            line_reg    <= line_next;
            a_valid_reg <= a_valid_next;
        end
    end

    // pixel payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            red_reg      <= red;
            green_reg    <= green;
            blue_reg     <= blue;
            pos_reg.col  <= col_reg;
            pos_reg.line <= line_reg;
        end
    end

    rthbp_luma u_luma (
        .red   (red_reg),
        .green (green_reg),
        .blue  (blue_reg),
        .limit (limit_reg),
        .white (white)
    );

    rthbp_pack u_pack (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (a_fire),
        .white       (white),
        .pos         (pos_reg),
        .can_take    (can_take),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .screen_byte (screen_byte),
        .page        (page),
        .page_offset (page_offset),
        .frame_end   (frame_end)
    );

endmodule

FILE: hdl/rthbp_checker.sv
// rthbp_checker: port level assertions for the bitplane packer, bound to the top level
// depends on rgb_to_hires_bitplane_packer

module rthbp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  screen_byte,
    input logic [1:0]  page,
    input logic [12:0] page_offset,
    input logic        frame_end
);

    // a held result item keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(screen_byte) && $stable(page)
            && $stable(page_offset) && $stable(frame_end))
        else $error("result item changed while stalled");

    // last byte of the frame lands at the top of page three
    a_frame_end_place: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> page == 2'd3 && page_offset == 13'd6143)
        else $error("frame end flagged at wrong place");

    // only three screen thirds exist
    a_third_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> page_offset[12:11] != 2'b11)
        else $error("page offset beyond page");

    // a new result must trace back to a pixel accepted at the input before it shows
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result item appeared without input");

endmodule

bind rgb_to_hires_bitplane_packer rthbp_checker u_rthbp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .screen_byte (screen_byte),
    .page        (page),
    .page_offset (page_offset),
    .frame_end   (frame_end)
);
